// ===== hdl/cllp_pkg.sv =====
package cllp_pkg;

   localparam int POOL_SLOTS_DEF = 32;

   typedef enum logic [3:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_BACK   = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_INSERT     = 4'd4,
      OP_DELETE     = 4'd5,
      OP_FIND       = 4'd6,
      OP_LENGTH     = 4'd7,
      OP_REVERSE    = 4'd8,
      OP_SORT       = 4'd9,
      OP_CLEAR      = 4'd10,
      OP_DUMP       = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // how a chain walk decides to stop
   typedef enum logic [1:0] {
      WK_FRONT = 2'd0,
      WK_TAIL  = 2'd1,
      WK_PRED  = 2'd2,
      WK_MATCH = 2'd3
   } walk_type;

endpackage

// ===== hdl/cursor_linked_list_pool.sv =====
// channel   ports                                        handshake
// request   req_type, req_value                          start & !busy
// response  rsp_status, rsp_elem_value, rsp_slot,        rsp_valid, once per beat
//           rsp_count, rsp_last
//
// Link and value stores are single-port-write RAMs with registered reads.
// Push/insert/pop/delete/find walk the chain link by link (tail walks read only links,
// compare walks also read each value). Sort costs one sorted-insert walk per element;
// dump gives one beat per cycle.
// Length, clear and unused codes answer straight from idle. Clear resets link valid bits at once.
// Synchronous reset gives the free chain 2..POOL_SLOTS-1; the receiver cannot stall.
module cursor_linked_list_pool
   import cllp_pkg::*;
#(
   parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_type,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_elem_value,
   output logic [4:0]         rsp_slot,
   output logic [4:0]         rsp_count,
   output logic               rsp_last
);

   localparam int SW = $clog2(POOL_SLOTS);
   typedef logic [SW-1:0] slot_type;

   typedef enum logic [21:0] {
      S_IDLE   = 22'b1 << 0,
      S_TAKE   = 22'b1 << 1,
      S_TAKE_D = 22'b1 << 2,
      S_FREE_D = 22'b1 << 3,
      S_W_RD   = 22'b1 << 4,
      S_W_LD   = 22'b1 << 5,
      S_W_VD   = 22'b1 << 6,
      S_AW     = 22'b1 << 7,
      S_INS_A  = 22'b1 << 8,
      S_INS_B  = 22'b1 << 9,
      S_U_RD   = 22'b1 << 10,
      S_U_D    = 22'b1 << 11,
      S_U_F    = 22'b1 << 12,
      S_U_G    = 22'b1 << 13,
      S_R0     = 22'b1 << 14,
      S_R1     = 22'b1 << 15,
      S_R2     = 22'b1 << 16,
      S_RLOOP  = 22'b1 << 17,
      S_R3     = 22'b1 << 18,
      S_D0     = 22'b1 << 19,
      S_D1     = 22'b1 << 20,
      S_D2     = 22'b1 << 21
   } state_type;

   localparam slot_type ONE_SLOT  = SW'(1);
   localparam slot_type LAST_SLOT = SW'(POOL_SLOTS - 1);

   // link value of an entry not written since reset or clear
   function automatic slot_type link_rst(input slot_type a);
      slot_type r;
      if (a == '0) begin
         r = SW'(2);
      end else if (a == ONE_SLOT || a == LAST_SLOT) begin
         r = '0;
      end else begin
         r = a + ONE_SLOT;
      end
      return r;
   endfunction

   function automatic walk_type walk_of(input logic [3:0] op);
      walk_type w;
      case (op) inside
         OP_PUSH_BACK, OP_POP_BACK: w = WK_TAIL;
         OP_INSERT, OP_SORT:        w = WK_PRED;
         OP_DELETE, OP_FIND:        w = WK_MATCH;
         default:                   w = WK_FRONT;
      endcase
      return w;
   endfunction

   slot_type               link_mem [POOL_SLOTS];
   logic [31:0]            value_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0]  vld_ff;
   slot_type               lrd_ff;
   logic signed [31:0]     vrd_ff;

   state_type          state_ff, state_in;
   logic [3:0]         op_ff, op_in;
   logic signed [31:0] x_ff, x_in;
   walk_type           mode_ff, mode_in;
   slot_type           cur_ff, cur_in;
   slot_type           prev_ff, prev_in;
   slot_type           lnk_ff, lnk_in;
   slot_type           s_ff, s_in;
   slot_type           j_ff, j_in;
   slot_type           p_ff, p_in;
   slot_type           cnt_ff, cnt_in;
   logic signed [31:0] ve_ff, ve_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   slot_type           rsp_slot_ff, rsp_slot_in;
   slot_type           rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               lw_en, vw_en, clear_go;
   slot_type           lw_addr, lw_data, lr_addr, vw_addr, vr_addr;
   logic [31:0]        vw_data;

   logic               emit_en, emit_last;
   status_type         emit_status;
   logic signed [31:0] emit_value;
   slot_type           emit_slot;
   logic               walk_stop;

   assign walk_stop = (mode_ff == WK_PRED) ? !(vrd_ff < x_ff) : (vrd_ff == x_ff);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      x_in = x_ff;
      mode_in = mode_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      lnk_in = lnk_ff;
      s_in = s_ff;
      j_in = j_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      ve_in = ve_ff;
      lw_en = 1'b0;
      lw_addr = '0;
      lw_data = '0;
      vw_en = 1'b0;
      vw_addr = '0;
      vw_data = '0;
      lr_addr = '0;
      vr_addr = '0;
      clear_go = 1'b0;
      emit_en = 1'b0;
      emit_status = ST_OK;
      emit_value = '0;
      emit_slot = '0;
      emit_last = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_type;
               x_in = req_value;
               mode_in = walk_of(req_type);
               cur_in = ONE_SLOT;
               prev_in = ONE_SLOT;
               case (req_type) inside
                  OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:     state_in = S_TAKE;
                  OP_POP_BACK, OP_POP_FRONT, OP_DELETE, OP_FIND: state_in = S_W_RD;
                  OP_REVERSE, OP_SORT:                        state_in = S_R0;
                  OP_DUMP:                                    state_in = S_D0;
                  OP_CLEAR: begin
                     clear_go = 1'b1;
                     cnt_in = '0;
                     emit_en = 1'b1;
                  end
                  default: emit_en = 1'b1;
               endcase
            end
         end
         S_TAKE: begin
            lr_addr = '0;
            state_in = S_TAKE_D;
         end
         S_TAKE_D: begin
            if (lrd_ff == '0) begin
               emit_en = 1'b1;
               emit_status = ST_FULL;
               state_in = S_IDLE;
            end else begin
               s_in = lrd_ff;
               lr_addr = lrd_ff;
               vw_en = 1'b1;
               vw_addr = lrd_ff;
               vw_data = x_ff;
               state_in = S_FREE_D;
            end
         end
         S_FREE_D: begin
            lw_en = 1'b1;
            lw_addr = '0;
            lw_data = lrd_ff;
            state_in = S_W_RD;
         end
         S_W_RD: begin
            lr_addr = cur_ff;
            state_in = S_W_LD;
         end
         S_W_LD: begin
            lnk_in = lrd_ff;
            if (lrd_ff == '0 || mode_ff == WK_FRONT) begin
               state_in = S_AW;
            end else if (mode_ff == WK_TAIL) begin
               prev_in = cur_ff;
               cur_in = lrd_ff;
               lr_addr = lrd_ff;
            end else begin
               vr_addr = lrd_ff;
               state_in = S_W_VD;
            end
         end
         S_W_VD: begin
            if (walk_stop) begin
               state_in = S_AW;
            end else begin
               cur_in = lnk_ff;
               lr_addr = lnk_ff;
               state_in = S_W_LD;
            end
         end
         S_AW: begin
            state_in = S_IDLE;
            case (op_ff) inside
               OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT, OP_REVERSE, OP_SORT:
                  state_in = S_INS_A;
               OP_POP_FRONT, OP_DELETE: begin
                  if (lnk_ff == '0) begin
                     emit_en = 1'b1;
                     emit_status = (op_ff == OP_DELETE) ? ST_NOT_FOUND : ST_EMPTY;
                  end else begin
                     j_in = cur_ff;
                     s_in = lnk_ff;
                     state_in = S_U_RD;
                  end
               end
               OP_POP_BACK: begin
                  if (cur_ff == ONE_SLOT) begin
                     emit_en = 1'b1;
                     emit_status = ST_EMPTY;
                  end else begin
                     j_in = prev_ff;
                     s_in = cur_ff;
                     state_in = S_U_RD;
                  end
               end
               OP_FIND: begin
                  emit_en = 1'b1;
                  if (lnk_ff == '0) begin
                     emit_status = ST_NOT_FOUND;
                  end else begin
                     emit_slot = cur_ff;
                  end
               end
               default: emit_en = 1'b1;
            endcase
         end
         S_INS_A: begin
            lw_en = 1'b1;
            lw_addr = s_ff;
            lw_data = lnk_ff;
            state_in = S_INS_B;
         end
         S_INS_B: begin
            lw_en = 1'b1;
            lw_addr = cur_ff;
            lw_data = s_ff;
            if (op_ff == OP_REVERSE || op_ff == OP_SORT) begin
               state_in = S_RLOOP;
            end else begin
               cnt_in = cnt_ff + ONE_SLOT;
               emit_en = 1'b1;
               emit_slot = s_ff;
               state_in = S_IDLE;
            end
         end
         S_U_RD: begin
            lr_addr = s_ff;
            vr_addr = s_ff;
            state_in = S_U_D;
         end
         S_U_D: begin
            lw_en = 1'b1;
            lw_addr = j_ff;
            lw_data = lrd_ff;
            ve_in = vrd_ff;
            lr_addr = '0;
            state_in = S_U_F;
         end
         S_U_F: begin
            lw_en = 1'b1;
            lw_addr = s_ff;
            lw_data = lrd_ff;
            state_in = S_U_G;
         end
         S_U_G: begin
            lw_en = 1'b1;
            lw_addr = '0;
            lw_data = s_ff;
            cnt_in = cnt_ff - ONE_SLOT;
            emit_en = 1'b1;
            emit_value = (op_ff == OP_DELETE) ? '0 : ve_ff;
            emit_slot = s_ff;
            state_in = S_IDLE;
         end
         S_R0: begin
            lr_addr = ONE_SLOT;
            state_in = S_R1;
         end
         S_R1: begin
            if (lrd_ff == '0) begin
               emit_en = 1'b1;
               state_in = S_IDLE;
            end else begin
               s_in = lrd_ff;
               lr_addr = lrd_ff;
               state_in = S_R2;
            end
         end
         S_R2: begin
            // first element is cut off as the sole element of the rebuilt chain (for reverse it ends as the tail)
            p_in = lrd_ff;
            lw_en = 1'b1;
            lw_addr = s_ff;
            lw_data = '0;
            state_in = S_RLOOP;
         end
         S_RLOOP: begin
            if (p_ff == '0) begin
               emit_en = 1'b1;
               state_in = S_IDLE;
            end else begin
               s_in = p_ff;
               lr_addr = p_ff;
               vr_addr = p_ff;
               state_in = S_R3;
            end
         end
         S_R3: begin
            p_in = lrd_ff;
            x_in = vrd_ff;
            cur_in = ONE_SLOT;
            state_in = S_W_RD;
         end
         S_D0: begin
            lr_addr = ONE_SLOT;
            state_in = S_D1;
         end
         S_D1: begin
            if (lrd_ff == '0) begin
               emit_en = 1'b1;
               emit_status = ST_EMPTY;
               state_in = S_IDLE;
            end else begin
               s_in = lrd_ff;
               lr_addr = lrd_ff;
               vr_addr = lrd_ff;
               state_in = S_D2;
            end
         end
         S_D2: begin
            emit_en = 1'b1;
            emit_value = vrd_ff;
            emit_slot = s_ff;
            emit_last = (lrd_ff == '0);
            if (lrd_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               s_in = lrd_ff;
               lr_addr = lrd_ff;
               vr_addr = lrd_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = emit_en;
      rsp_status_in = rsp_status_ff;
      rsp_value_in = rsp_value_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in = rsp_last_ff;
      if (emit_en) begin
         rsp_status_in = emit_status;
         rsp_value_in = emit_value;
         rsp_slot_in = emit_slot;
         rsp_count_in = cnt_in;
         rsp_last_in = emit_last;
      end
   end

   // memories, read data registered with write forwarding
   always_ff @(posedge clock) begin
      if (lw_en) begin
         link_mem[lw_addr] <= lw_data;
      end
      if (vw_en) begin
         value_mem[vw_addr] <= vw_data;
      end
      if (lw_en && lw_addr == lr_addr) begin
         lrd_ff <= lw_data;
      end else if (vld_ff[lr_addr]) begin
         lrd_ff <= link_mem[lr_addr];
      end else begin
         lrd_ff <= link_rst(lr_addr);
      end
      if (vw_en && vw_addr == vr_addr) begin
         vrd_ff <= vw_data;
      end else begin
         vrd_ff <= value_mem[vr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         vld_ff <= '0;
      end else if (lw_en) begin
         vld_ff[lw_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      x_ff <= x_in;
      mode_ff <= mode_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      lnk_ff <= lnk_in;
      s_ff <= s_in;
      j_ff <= j_in;
      p_ff <= p_in;
      ve_ff <= ve_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_elem_value = rsp_value_ff;
   assign rsp_slot = 5'(rsp_slot_ff);
   assign rsp_count = 5'(rsp_count_ff);
   assign rsp_last = rsp_last_ff;

   // dump beats come back to back until the last one
   a_dump_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("dump burst broken");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy after final beat");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SW'(POOL_SLOTS - 2))
      else $error("element count exceeds pool");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> cnt_ff == SW'(POOL_SLOTS - 2))
      else $error("pool full with free slots left");

endmodule
